[rtl/tmt_pkg.sv]
// tmt_pkg: command codes and the stage and result records of the timeout marker table.
// Stands alone; the other files use it through scoped names.
package tmt_pkg;

	localparam int unsigned CountW = 32;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_SET   = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_CHECK = 3'd3,
		CMD_DIFF  = 3'd4
	} cmd_t;

	// item in flight while the stamp memory read completes
	typedef struct packed {
		cmd_t              cmd;
		logic              idx_ok;
		logic              enabled;
		logic [CountW-1:0] count;
		logic [CountW-1:0] operand;
	} stage_t;

	typedef struct packed {
		logic              accepted;
		logic              expired;
		logic [CountW-1:0] time_value;
	} result_t;

endpackage

[rtl/tmt_stamp_ram.sv]
// tmt_stamp_ram: marker time stamp storage, one write and one read port, registered read.
// Uses tmt_pkg for the stamp width.
module tmt_stamp_ram #(
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = 3
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [tmt_pkg::CountW-1:0] wdata,
	input  logic                      re,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [tmt_pkg::CountW-1:0] rdata
);

	logic [tmt_pkg::CountW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tmt_eval.sv]
// tmt_eval: forms the result of one item from its stage record and the stamp read.
// Uses tmt_pkg for cmd_t, stage_t and result_t.
module tmt_eval (
	input  tmt_pkg::stage_t            stage,
	input  logic [tmt_pkg::CountW-1:0] stamp,
	output tmt_pkg::result_t           result
);

	logic [tmt_pkg::CountW-1:0] since_stamp;
	logic [tmt_pkg::CountW-1:0] since_ref;

	// both wrap modulo 2^32
	assign since_stamp = stage.count - stamp;
	assign since_ref   = stage.count - stage.operand;

	always_comb begin
		result.accepted   = 1'b0;
		result.expired    = 1'b0;
		result.time_value = stage.count;
		case (stage.cmd)
			tmt_pkg::CMD_TICK: begin
				result.accepted = 1'b1;
			end
			tmt_pkg::CMD_SET, tmt_pkg::CMD_STOP: begin
				result.accepted = stage.idx_ok;
			end
			tmt_pkg::CMD_CHECK: begin
				result.accepted = stage.idx_ok;
				result.expired  = stage.idx_ok && stage.enabled &&
					(since_stamp >= stage.operand);
			end
			tmt_pkg::CMD_DIFF: begin
				result.accepted   = 1'b1;
				result.time_value = since_ref;
			end
			default: begin
				result.accepted = 1'b0;
			end
		endcase
	end

endmodule

[rtl/timeout_marker_table_unit.sv]
// timeout_marker_table_unit: millisecond counter with a table of enabled time markers.
// From input accept to result valid: stamp memory read with the stage 1 record, then result register.
// Throughput: one item per cycle unless the output stalls; the stamp port is read once per item.
// Reset: count and marker enables cleared at once; stamps are undefined until a set.
// Uses tmt_pkg, tmt_stamp_ram and tmt_eval.
module timeout_marker_table_unit #(
	parameter int unsigned MARKERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] command, [10:3] marker_index, [42:11] operand_value, [47:43] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [1] expired, [33:2] time_value, [39:34] zero
	output logic [39:0] m_tdata
);

	localparam int unsigned IdxW = (MARKERS > 1) ? $clog2(MARKERS) : 1;

	// input fields
	tmt_pkg::cmd_t               in_cmd;
	logic [7:0]                  in_idx;
	logic [tmt_pkg::CountW-1:0]  in_operand;
	logic                        in_idx_ok;
	logic [IdxW-1:0]             in_addr;

	// state
	logic [tmt_pkg::CountW-1:0]  count_q;
	logic [MARKERS-1:0]          enabled_q;

	// pipeline
	logic                        s_accept;
	logic                        advance;
	logic                        valid_s1;
	tmt_pkg::stage_t             stage_s1;
	logic [tmt_pkg::CountW-1:0]  stamp_rd;
	tmt_pkg::result_t            result;
	logic                        out_valid_q;
	tmt_pkg::result_t            out_q;

	assign in_cmd     = tmt_pkg::cmd_t'(s_tdata[2:0]);
	assign in_idx     = s_tdata[10:3];
	assign in_operand = s_tdata[42:11];
	assign in_idx_ok  = {1'b0, in_idx} < 9'(MARKERS);
	assign in_addr    = in_idx[IdxW-1:0];

	// stage 1 moves on when the result register is free or being taken
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// All state updates land at accept, so the next item's read already sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			enabled_q <= '0;
		end else if (s_accept) begin
			case (in_cmd)
				tmt_pkg::CMD_TICK: begin
					count_q <= count_q + 32'd1;
				end
				tmt_pkg::CMD_SET: begin
					if (in_idx_ok) begin
						enabled_q[in_addr] <= 1'b1;
					end
				end
				tmt_pkg::CMD_STOP: begin
					if (in_idx_ok) begin
						enabled_q[in_addr] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	tmt_stamp_ram #(
		.DEPTH  (MARKERS),
		.ADDR_W (IdxW)
	) u_stamp_ram (
		.clk   (clk),
		.we    (s_accept && (in_cmd == tmt_pkg::CMD_SET) && in_idx_ok),
		.waddr (in_addr),
		.wdata (count_q),
		.re    (s_accept),
		.raddr (in_addr),
		.rdata (stamp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// count as the item sees it: after the increment for a tick
	always_ff @(posedge clk) begin
		if (s_accept) begin
			stage_s1.cmd     <= in_cmd;
			stage_s1.idx_ok  <= in_idx_ok;
			stage_s1.enabled <= in_idx_ok && enabled_q[in_addr];
			stage_s1.count   <= (in_cmd == tmt_pkg::CMD_TICK) ? count_q + 32'd1 : count_q;
			stage_s1.operand <= in_operand;
		end
	end

	tmt_eval u_eval (
		.stage  (stage_s1),
		.stamp  (stamp_rd),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.time_value, out_q.expired, out_q.accepted};

	// a tick bumps the count by exactly one
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (in_cmd == tmt_pkg::CMD_TICK) |=> count_q == $past(count_q) + 32'd1)
		else $error("count did not advance on tick");

	// a stalled stage 1 blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_tready)
		else $error("input taken while stage 1 stalled");

	// a set in range enables its marker
	a_set_enables: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (in_cmd == tmt_pkg::CMD_SET) && in_idx_ok |=> enabled_q[$past(in_addr)])
		else $error("set did not enable marker");

	// expiry only ever reported for an accepted check
	a_expired_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.expired |-> out_q.accepted)
		else $error("expired without accepted");

endmodule

[test/tb_timeout_marker_table_unit.sv]
// tb_timeout_marker_table_unit: drives command items into the timeout marker table and
// checks every result against an in-bench prediction of the count and the marker table.
// Depends on tmt_pkg and timeout_marker_table_unit only.
module tb_timeout_marker_table_unit;

	localparam int unsigned MARKERS      = 8;
	localparam int unsigned RANDOM_ITEMS = 1800;
	// Hard bound on the whole run, with a wide margin over the worst case per item.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// Extra wait after the last owed result, for any stray result.
	localparam int unsigned DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [2:0] command, [10:3] marker_index, [42:11] operand_value, [47:43] zero
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [0] accepted, [1] expired, [33:2] time_value, [39:34] zero
	logic [39:0] m_tdata;

	bit          calm;        // no idling on either side while set
	int unsigned stall_left;
	int unsigned cycles;

	// Tracks the millisecond count and the marker table, and holds the results
	// still owed by the block, oldest first.
	class marker_scoreboard;
		logic [31:0]      now_ms;
		logic [31:0]      stamp_ms [MARKERS];
		bit               armed [MARKERS];
		tmt_pkg::result_t awaited [$];
		int unsigned      errors;

		function new();
			errors = 0;
			now_ms = '0;
			foreach (armed[i]) begin
				armed[i]    = 1'b0;
				stamp_ms[i] = '0;
			end
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $realtime, what);
			errors++;
		endtask

		// Apply one accepted item to the table and queue the result it owes.
		function void note_item(logic [2:0] code, logic [7:0] idx, logic [31:0] operand);
			tmt_pkg::result_t r;
			logic             in_table;
			logic [31:0]      since;
			in_table   = (idx < MARKERS);
			r.accepted = 1'b0;
			r.expired  = 1'b0;
			case (code)
				tmt_pkg::CMD_TICK: begin
					now_ms     = now_ms + 32'd1;
					r.accepted = 1'b1;
				end
				tmt_pkg::CMD_SET: if (in_table) begin
					stamp_ms[idx] = now_ms;
					armed[idx]    = 1'b1;
					r.accepted    = 1'b1;
				end
				tmt_pkg::CMD_STOP: if (in_table) begin
					armed[idx] = 1'b0;
					r.accepted = 1'b1;
				end
				tmt_pkg::CMD_CHECK: if (in_table) begin
					since      = now_ms - stamp_ms[idx];   // wraps mod 2^32
					r.accepted = 1'b1;
					r.expired  = armed[idx] && (since >= operand);
				end
				tmt_pkg::CMD_DIFF: r.accepted = 1'b1;
				default: ;    // unknown code: nothing changes, not accepted
			endcase
			r.time_value = (code == tmt_pkg::CMD_DIFF) ? now_ms - operand : now_ms;
			awaited.push_back(r);
		endfunction

		task check_result(logic [39:0] data);
			tmt_pkg::result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with nothing outstanding", data));
				return;
			end
			want = awaited.pop_front();
			if (data[0] !== want.accepted)
				report($sformatf("accepted %b, want %b", data[0], want.accepted));
			if (data[1] !== want.expired)
				report($sformatf("expired %b, want %b", data[1], want.expired));
			if (data[33:2] !== want.time_value)
				report($sformatf("time_value %h, want %h", data[33:2], want.time_value));
		endtask
	endclass

	marker_scoreboard sb = new();

	timeout_marker_table_unit #(
		.MARKERS(MARKERS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one item from a falling edge, hold it until accepted, note it in the
	// scoreboard and return at the next falling edge. Random gaps before the item.
	task send_item(logic [2:0] code, logic [7:0] idx, logic [31:0] operand);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, operand, idx, code};
		do @(posedge clk); while (!s_tready);
		sb.note_item(code, idx, operand);
		@(negedge clk);
	endtask

	// Mostly well-formed traffic: ticks move the count, checks aim their timeout
	// right at the elapsed time of the marker so both outcomes come up often.
	task pick_item(output logic [2:0] code, output logic [7:0] idx, output logic [31:0] operand);
		int unsigned roll;
		logic [31:0] since;
		roll    = $urandom_range(0, 99);
		idx     = 8'($urandom_range(0, MARKERS - 1));
		operand = $urandom;
		if (roll < 30) begin
			code = tmt_pkg::CMD_TICK;
		end else if (roll < 45) begin
			code = tmt_pkg::CMD_SET;
		end else if (roll < 53) begin
			code = tmt_pkg::CMD_STOP;
		end else if (roll < 78) begin
			code  = tmt_pkg::CMD_CHECK;
			since = sb.now_ms - sb.stamp_ms[idx];
			case ($urandom_range(0, 4))
				0: operand = since;
				1: operand = since + 32'd1;
				2: operand = since - 32'd1;
				3: operand = $urandom_range(0, 64);
				default: ;
			endcase
		end else if (roll < 90) begin
			code = tmt_pkg::CMD_DIFF;
			if ($urandom_range(0, 1) == 0)
				operand = sb.now_ms - $urandom_range(0, 40);
		end else if (roll < 95) begin
			// index past the end of the table
			idx = 8'($urandom_range(MARKERS, 255));
			case ($urandom_range(0, 2))
				0: code = tmt_pkg::CMD_SET;
				1: code = tmt_pkg::CMD_STOP;
				default: code = tmt_pkg::CMD_CHECK;
			endcase
		end else begin
			// codes above the last defined one
			code = 3'(tmt_pkg::CMD_DIFF + $urandom_range(1, 3));
			idx  = 8'($urandom);
		end
	endtask

	// Result side: random stall bursts unless calm.
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Hard stop if the block hangs.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL timeout_marker_table_unit");
		$finish;
	end

	initial begin
		logic [2:0]  code;
		logic [7:0]  idx;
		logic [31:0] operand;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		calm     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Differences at count zero, both extremes of the operand.
		send_item(tmt_pkg::CMD_DIFF, 8'd0, 32'h0000_0000);
		send_item(tmt_pkg::CMD_DIFF, 8'd0, 32'hFFFF_FFFF);
		// Stamp every marker so no check ever reads an unwritten stamp.
		for (int m = 0; m < MARKERS; m++)
			send_item(tmt_pkg::CMD_SET, 8'(m), 32'h0);
		send_item(tmt_pkg::CMD_TICK, 8'd0, 32'h0);
		send_item(tmt_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
		// Elapsed is 2: timeouts of 0 and 2 expire, 3 and all-ones do not.
		send_item(tmt_pkg::CMD_CHECK, 8'd0, 32'd0);
		send_item(tmt_pkg::CMD_CHECK, 8'd0, 32'd2);
		send_item(tmt_pkg::CMD_CHECK, 8'd0, 32'd3);
		send_item(tmt_pkg::CMD_CHECK, 8'd7, 32'hFFFF_FFFF);
		// Stopped marker: accepted but never expired.
		send_item(tmt_pkg::CMD_STOP, 8'd3, 32'h0);
		send_item(tmt_pkg::CMD_CHECK, 8'd3, 32'd0);
		// Index out of the table.
		send_item(tmt_pkg::CMD_SET, 8'hFF, 32'h0);
		send_item(tmt_pkg::CMD_STOP, 8'(MARKERS), 32'h0);
		send_item(tmt_pkg::CMD_CHECK, 8'd200, 32'd0);
		// Unknown codes.
		for (int k = 1; k <= 3; k++)
			send_item(3'(tmt_pkg::CMD_DIFF + k), 8'hFF, 32'hFFFF_FFFF);
		send_item(tmt_pkg::CMD_DIFF, 8'd0, 32'h8000_0000);

		// Random part: idling, a calm stretch, idling again, then calm to the end.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 800 && i < 1200) || (i >= 1600);
			pick_item(code, idx, operand);
			send_item(code, idx, operand);
		end
		s_tvalid <= 1'b0;

		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS timeout_marker_table_unit");
		end else begin
			$display("FAIL timeout_marker_table_unit");
		end
		$finish;
	end

endmodule

[timeout_marker_table_unit.f]
rtl/tmt_pkg.sv
rtl/tmt_stamp_ram.sv
rtl/tmt_eval.sv
rtl/timeout_marker_table_unit.sv
test/tb_timeout_marker_table_unit.sv
